// File: rtl/apc_pkg.sv
// ----------------------------------------------------------------------------
// apc_pkg
// shared constants, result codes and status words of the atkin prime classifier
// ----------------------------------------------------------------------------
package apc_pkg;

    localparam int CANDIDATE_BITS_DEF = 20;
    localparam int COUNT_BITS         = 10;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam int RES_BITS           = 6;
    localparam int RES_MOD            = 60;

    typedef enum logic [1:0] {
        FORM_NONE       = 2'd0,
        FORM_4XX_PLUS   = 2'd1,
        FORM_3XX_PLUS   = 2'd2,
        FORM_3XX_MINUS  = 2'd3
    } t_form;

    typedef struct packed {
        logic                done;
        logic [RES_BITS-1:0] residue;
    } t_res_stat;

    typedef struct packed {
        logic                  done;
        logic                  odd;
        logic [COUNT_BITS-1:0] count;
    } t_cnt_stat;

    typedef struct packed {
        logic done;
        logic square_free;
    } t_sqf_stat;

    // form chosen by n mod 60, none when the residue shares a factor with 60
    function automatic t_form res_form(input logic [RES_BITS-1:0] r);
        t_form f;
        case (r) inside
            6'd1, 6'd13, 6'd17, 6'd29, 6'd37, 6'd41, 6'd49, 6'd53: f = FORM_4XX_PLUS;
            6'd7, 6'd19, 6'd31, 6'd43:                             f = FORM_3XX_PLUS;
            6'd11, 6'd23, 6'd47, 6'd59:                            f = FORM_3XX_MINUS;
            default:                                               f = FORM_NONE;
        endcase
        return f;
    endfunction

endpackage

// File: rtl/apc_residue.sv
// ----------------------------------------------------------------------------
// apc_residue
// candidate modulo 60 by a nibble fold, registered on start
// ----------------------------------------------------------------------------
module apc_residue #(
    parameter int BITS = apc_pkg::CANDIDATE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [BITS-1:0]        i_value,
    output apc_pkg::t_res_stat     o_stat
);
    import apc_pkg::*;

    localparam int MW     = BITS - 2;
    localparam int NIBS   = (MW + 3) / 4;
    localparam int MOD_LO = RES_MOD / 4;

    logic                r_done;
    logic [RES_BITS-1:0] r_res;

    logic [4*NIBS-1:0]   w_m;
    logic [7:0]          w_sum;
    logic [4:0]          w_fold;
    logic [3:0]          w_lo;

    // n mod 60 is 4 * ((n >> 2) mod 15) + n[1:0], and 16 folds to 1 mod 15
    always_comb begin
        w_m   = (4*NIBS)'(i_value[BITS-1:2]);
        w_sum = '0;
        for (int k = 0; k < NIBS; k++) begin
            w_sum = w_sum + 8'(w_m[4*k +: 4]);
        end
        w_fold = 5'(w_sum[3:0]) + 5'(w_sum[7:4]);
        if (w_fold >= 5'(MOD_LO)) begin
            w_lo = 4'(w_fold - 5'(MOD_LO));
        end else begin
            w_lo = w_fold[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_res <= {w_lo, i_value[1:0]};
        end
    end

    assign o_stat.done    = r_done;
    assign o_stat.residue = r_res;

endmodule

// File: rtl/apc_form_count.sv
// ----------------------------------------------------------------------------
// apc_form_count
// two-pointer walk over x and y that counts the solutions of the chosen form
// ----------------------------------------------------------------------------
module apc_form_count #(
    parameter int BITS = apc_pkg::CANDIDATE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  apc_pkg::t_form         i_form,
    input  logic [BITS-1:0]        i_n,
    output apc_pkg::t_cnt_stat     o_stat
);
    import apc_pkg::*;

    localparam int HB = (BITS + 1) / 2;
    localparam int W  = BITS + 4;
    localparam int XW = HB + 2;
    localparam int YW = HB + 1;

    logic                  r_busy;
    logic                  r_done;
    logic [XW-1:0]         r_x;
    logic [W-1:0]          r_sx;
    logic [YW-1:0]         r_y;
    logic [W-1:0]          r_sy;
    logic [COUNT_BITS-1:0] r_count;
    logic                  r_odd;

    logic [W-1:0] w_n;
    logic [W-1:0] w_kx;
    logic [W-1:0] w_lim;
    logic [W-1:0] w_v;
    logic [W-1:0] w_sx3;
    logic [W-1:0] w_sx_inc;
    logic [W-1:0] w_sy_inc;
    logic [W-1:0] w_sy_dec;
    logic         w_end;
    logic         w_hit;
    logic         w_lt;

    always_comb begin
        w_n   = W'(i_n);
        w_sx3 = r_sx + (r_sx << 1);
        case (i_form)
            FORM_4XX_PLUS: begin
                w_kx  = r_sx << 2;
                w_lim = r_sx << 2;
            end
            FORM_3XX_PLUS: begin
                w_kx  = w_sx3;
                w_lim = w_sx3;
            end
            default: begin
                w_kx  = w_sx3;
                w_lim = r_sx << 1;
            end
        endcase
        w_v      = (i_form == FORM_3XX_MINUS) ? (w_kx - r_sy) : (w_kx + r_sy);
        w_end    = (w_lim >= w_n);
        w_hit    = (w_v == w_n);
        w_lt     = (w_v < w_n);
        w_sx_inc = r_sx + W'({r_x, 1'b1});
        w_sy_inc = r_sy + W'({r_y, 1'b1});
        w_sy_dec = r_sy - W'({r_y, 1'b0}) + W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && w_end) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x     <= XW'(1);
            r_sx    <= W'(1);
            r_count <= '0;
            r_odd   <= 1'b0;
            if (i_form == FORM_3XX_MINUS) begin
                r_y  <= '0;
                r_sy <= '0;
            end else begin
                r_y  <= YW'(1) << HB;
                r_sy <= W'(1) << (2 * HB);
            end
        end else if (r_busy && !w_end) begin
            if (w_hit || w_lt) begin
                r_x  <= r_x + XW'(1);
                r_sx <= w_sx_inc;
                if (w_hit) begin
                    r_odd <= ~r_odd;
                    if (r_count != COUNT_MAX) begin
                        r_count <= r_count + COUNT_BITS'(1);
                    end
                end
            end else if (i_form == FORM_3XX_MINUS) begin
                r_y  <= r_y + YW'(1);
                r_sy <= w_sy_inc;
            end else begin
                r_y  <= r_y - YW'(1);
                r_sy <= w_sy_dec;
            end
        end
    end

    assign o_stat.done  = r_done;
    assign o_stat.odd   = r_odd;
    assign o_stat.count = r_count;

endmodule

// File: rtl/apc_sqfree.sv
// ----------------------------------------------------------------------------
// apc_sqfree
// square-free test: restoring remainder of n by each odd square from 9 up to n
// ----------------------------------------------------------------------------
module apc_sqfree #(
    parameter int BITS = apc_pkg::CANDIDATE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [BITS-1:0]        i_n,
    output apc_pkg::t_sqf_stat     o_stat
);
    import apc_pkg::*;

    localparam int HB = (BITS + 1) / 2;
    localparam int IW = HB + 1;
    localparam int DW = BITS + 1;
    localparam int BW = $clog2(BITS);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CHECK = 3'b010,
        S_DIV   = 3'b100
    } t_sqf_state;

    t_sqf_state      r_state;
    logic            r_done;
    logic            r_sf;
    logic [IW-1:0]   r_i;
    logic [DW-1:0]   r_d;
    logic [DW-1:0]   r_rem;
    logic [BITS-1:0] r_shift;
    logic [BW-1:0]   r_bit;

    logic [DW:0]     w_t;
    logic [DW-1:0]   n_rem;
    logic [DW-1:0]   w_d_next;
    logic            w_last;

    always_comb begin
        w_t = {r_rem, r_shift[BITS-1]};
        if (w_t >= {1'b0, r_d}) begin
            n_rem = DW'(w_t - {1'b0, r_d});
        end else begin
            n_rem = w_t[DW-1:0];
        end
        w_d_next = r_d + DW'({r_i, 2'b00}) + DW'(4);
        w_last   = (r_bit == BW'(BITS-1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_d > DW'(i_n)) begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_last) begin
                        if (n_rem == '0) begin
                            r_state <= S_IDLE;
                            r_done  <= 1'b1;
                        end else begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_i <= IW'(3);
                    r_d <= DW'(9);
                end
            end
            S_CHECK: begin
                r_rem   <= '0;
                r_shift <= i_n;
                r_bit   <= '0;
                r_sf    <= 1'b1;
            end
            S_DIV: begin
                r_rem   <= n_rem;
                r_shift <= r_shift << 1;
                r_bit   <= r_bit + BW'(1);
                if (w_last) begin
                    if (n_rem == '0) begin
                        r_sf <= 1'b0;
                    end else begin
                        r_i <= r_i + IW'(2);
                        r_d <= w_d_next;
                    end
                end
            end
            default: begin
                r_sf <= r_sf;
            end
        endcase
    end

    assign o_stat.done        = r_done;
    assign o_stat.square_free = r_sf;

endmodule

// File: rtl/atkin_prime_classifier.sv
// ----------------------------------------------------------------------------
// atkin_prime_classifier
// classifies one candidate word as prime or not by the quadratic forms of atkin
// ----------------------------------------------------------------------------
// One candidate word is taken at a time; o_in_ready stays low until its result
// has been moved into the output register, which may still be waiting to be
// taken. The mod-60 residue comes from a nibble fold of the registered
// candidate. Small or excluded values then go straight to the output state.
// Otherwise the form walk runs the x/y two-pointer search, about
// 2^ceil(BITS/2) + sqrt(n/2) steps at most. Only when the solution count is
// odd does the square-free pass run: for each odd i from 3 with i*i <= n it
// runs one restoring remainder of n by i*i, and it stops at the first zero
// remainder.
// ----------------------------------------------------------------------------
module atkin_prime_classifier #(
    parameter int CANDIDATE_BITS = apc_pkg::CANDIDATE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [CANDIDATE_BITS-1:0]      i_candidate,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_is_prime,
    output logic [1:0]                     o_form_used,
    output logic [apc_pkg::COUNT_BITS-1:0] o_solution_count
);
    import apc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_RESIDUE = 5'b00010,
        S_COUNT   = 5'b00100,
        S_SQFREE  = 5'b01000,
        S_OUTPUT  = 5'b10000
    } t_state;

    t_state                    r_state;
    logic                      r_out_valid;
    logic                      r_res_start;
    logic                      r_cnt_start;
    logic                      r_sqf_start;
    logic [CANDIDATE_BITS-1:0] r_n;
    t_form                     r_form;
    logic                      r_prime;
    logic [COUNT_BITS-1:0]     r_count;
    logic                      r_o_prime;
    t_form                     r_o_form;
    logic [COUNT_BITS-1:0]     r_o_count;

    t_res_stat w_res;
    t_cnt_stat w_cnt;
    t_sqf_stat w_sqf;
    t_form     w_form;
    logic      w_small_prime;
    logic      w_walk;

    apc_residue #(
        .BITS (CANDIDATE_BITS)
    ) u_residue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_res_start),
        .i_value (r_n),
        .o_stat  (w_res)
    );

    apc_form_count #(
        .BITS (CANDIDATE_BITS)
    ) u_form_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cnt_start),
        .i_form  (r_form),
        .i_n     (r_n),
        .o_stat  (w_cnt)
    );

    apc_sqfree #(
        .BITS (CANDIDATE_BITS)
    ) u_sqfree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sqf_start),
        .i_n     (r_n),
        .o_stat  (w_sqf)
    );

    always_comb begin
        w_form        = res_form(w_res.residue);
        w_small_prime = (r_n == CANDIDATE_BITS'(2)) || (r_n == CANDIDATE_BITS'(3)) ||
                        (r_n == CANDIDATE_BITS'(5));
        w_walk        = !w_small_prime && (r_n >= CANDIDATE_BITS'(2)) &&
                        (w_form != FORM_NONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_res_start <= 1'b0;
            r_cnt_start <= 1'b0;
            r_sqf_start <= 1'b0;
        end else begin
            r_res_start <= 1'b0;
            r_cnt_start <= 1'b0;
            r_sqf_start <= 1'b0;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_res_start <= 1'b1;
                        r_state     <= S_RESIDUE;
                    end
                end
                S_RESIDUE: begin
                    if (w_res.done) begin
                        if (w_walk) begin
                            r_cnt_start <= 1'b1;
                            r_state     <= S_COUNT;
                        end else begin
                            r_state <= S_OUTPUT;
                        end
                    end
                end
                S_COUNT: begin
                    if (w_cnt.done) begin
                        if (w_cnt.odd) begin
                            r_sqf_start <= 1'b1;
                            r_state     <= S_SQFREE;
                        end else begin
                            r_state <= S_OUTPUT;
                        end
                    end
                end
                S_SQFREE: begin
                    if (w_sqf.done) begin
                        r_state <= S_OUTPUT;
                    end
                end
                S_OUTPUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_n <= i_candidate;
                end
            end
            S_RESIDUE: begin
                if (w_res.done) begin
                    r_form  <= w_walk ? w_form : FORM_NONE;
                    r_prime <= w_small_prime;
                    r_count <= '0;
                end
            end
            S_COUNT: begin
                if (w_cnt.done) begin
                    r_count <= w_cnt.count;
                    r_prime <= 1'b0;
                end
            end
            S_SQFREE: begin
                if (w_sqf.done) begin
                    r_prime <= w_sqf.square_free;
                end
            end
            S_OUTPUT: begin
                if (!r_out_valid || i_out_ready) begin
                    r_o_prime <= r_prime;
                    r_o_form  <= r_form;
                    r_o_count <= r_count;
                end
            end
            default: begin
                r_prime <= r_prime;
            end
        endcase
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_is_prime       = r_o_prime;
    assign o_form_used      = r_o_form;
    assign o_solution_count = r_o_count;

    // one word in flight at a time
    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken again while a word is in flight");

    a_no_form_no_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_form_used == FORM_NONE)) |-> (o_solution_count == '0))
        else $error("solution count without a form");

    // a prime from a form walk has an odd count unless saturated
    a_prime_odd_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_prime && (o_form_used != FORM_NONE) &&
         (o_solution_count != COUNT_MAX)) |-> o_solution_count[0])
        else $error("prime reported with an even solution count");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the atkin prime classifier
// ----------------------------------------------------------------------------
// A short table of candidates covers the trivial primes, the excluded values,
// the field extremes, every residue form and squared factors. Random
// candidates follow, most of them coprime to 30 so that they reach the form
// search and, with an odd count, the square-free pass. Every result word is
// compared with a bit-exact prediction taken at input acceptance. Both
// channels idle in random bursts, and the sink holds off once for a long
// stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_top;

    import apc_pkg::*;

    localparam int          CAND_W         = CANDIDATE_BITS_DEF;
    localparam int unsigned CAND_MAX       = (1 << CAND_W) - 1;
    localparam int unsigned SMALL_MAX      = 65535;
    localparam int          RAND_ITEMS     = 117;
    localparam int          HOLD_CYCLES    = 3000;
    localparam int          HOLD_AFTER     = 10;
    localparam int          DRAIN_CYCLES   = 200;
    localparam int          WATCHDOG_LIMIT = 100000;
    localparam int unsigned COPRIME30 [8]  = '{1, 7, 11, 13, 17, 19, 23, 29};

    typedef struct packed {
        logic                  is_prime;
        t_form                 form;
        logic [COUNT_BITS-1:0] count;
    } t_verdict;

    typedef enum logic [1:0] {
        ROW_PREDICT   = 2'd0,
        ROW_NOT_PRIME = 2'd1,
        ROW_PRIME     = 2'd2
    } t_row_kind;

    typedef struct packed {
        logic [CAND_W-1:0] cand;
        t_row_kind         kind;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [CAND_W-1:0]     i_candidate;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic                  o_is_prime;
    logic [1:0]            o_form_used;
    logic [COUNT_BITS-1:0] o_solution_count;

    t_verdict pending_verdicts [$];
    t_dir_row dir_rows [$];
    int       err_count;
    bit       quiet_phase;

    atkin_prime_classifier #(
        .CANDIDATE_BITS (CAND_W)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_candidate      (i_candidate),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_is_prime       (o_is_prime),
        .o_form_used      (o_form_used),
        .o_solution_count (o_solution_count)
    );

    initial i_clk = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit perfect_square(input longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        int              b;
        r = 0;
        for (b = 11; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) r = t;
        end
        return r * r == v;
    endfunction

    function automatic t_form residue_form(input int unsigned r);
        case (r)
            1, 13, 17, 29, 37, 41, 49, 53: return FORM_4XX_PLUS;
            7, 19, 31, 43:                 return FORM_3XX_PLUS;
            default:                       return FORM_3XX_MINUS;
        endcase
    endfunction

    function automatic longint unsigned count_solutions(input longint unsigned n,
                                                        input t_form f);
        longint unsigned x;
        longint unsigned t;
        longint unsigned cnt;
        cnt = 0;
        if (f == FORM_4XX_PLUS) begin
            for (x = 1; 4 * x * x < n; x++)
                if (perfect_square(n - 4 * x * x)) cnt++;
        end else if (f == FORM_3XX_PLUS) begin
            for (x = 1; 3 * x * x < n; x++)
                if (perfect_square(n - 3 * x * x)) cnt++;
        end else begin
            for (x = 1; 2 * x * x < n; x++) begin
                t = 3 * x * x;
                if (t > n && perfect_square(t - n)) cnt++;
            end
        end
        return cnt;
    endfunction

    function automatic bit no_square_factor(input longint unsigned n);
        longint unsigned i;
        for (i = 3; i * i <= n; i += 2)
            if (n % (i * i) == 0) return 1'b0;
        return 1'b1;
    endfunction

    function automatic t_verdict classify(input logic [CAND_W-1:0] cand);
        t_verdict        v;
        longint unsigned n;
        longint unsigned total;
        n          = 64'(cand);
        v.is_prime = 1'b0;
        v.form     = FORM_NONE;
        v.count    = '0;
        if (n == 2 || n == 3 || n == 5) begin
            v.is_prime = 1'b1;
        end else if (n >= 2 && n % 2 != 0 && n % 3 != 0 && n % 5 != 0) begin
            v.form     = residue_form(32'(n % RES_MOD));
            total      = count_solutions(n, v.form);
            v.is_prime = total[0] && no_square_factor(n);
            v.count    = (total > COUNT_MAX) ? COUNT_MAX : total[COUNT_BITS-1:0];
        end
        return v;
    endfunction

    function automatic logic [CAND_W-1:0] pick_candidate();
        int unsigned sel;
        int unsigned top;
        int unsigned k;
        sel = $urandom_range(0, 9);
        if (sel < 2) return CAND_W'($urandom_range(0, CAND_MAX));
        top = (sel == 2) ? CAND_MAX : SMALL_MAX;
        k   = $urandom_range(0, (top - 29) / 30);
        return CAND_W'(30 * k + COPRIME30[$urandom_range(0, 7)]);
    endfunction

    task automatic add_row(input logic [CAND_W-1:0] cand, input t_row_kind kind);
        t_dir_row r;
        r.cand = cand;
        r.kind = kind;
        dir_rows.push_back(r);
    endtask

    task automatic offer_word(input logic [CAND_W-1:0] cand, input t_verdict want);
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_candidate <= cand;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        pending_verdicts.push_back(want);
    endtask

    initial begin : source
        t_verdict want;
        int       i;
        err_count   = 0;
        quiet_phase = 1'b0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_candidate <= '0;

        add_row(0,       ROW_NOT_PRIME);
        add_row(1,       ROW_NOT_PRIME);
        add_row(2,       ROW_PRIME);
        add_row(3,       ROW_PRIME);
        add_row(5,       ROW_PRIME);
        add_row(4,       ROW_NOT_PRIME);
        add_row(9,       ROW_NOT_PRIME);
        add_row(25,      ROW_NOT_PRIME);
        add_row(CAND_MAX,     ROW_NOT_PRIME);
        add_row(CAND_MAX - 1, ROW_NOT_PRIME);
        add_row(7,       ROW_PREDICT);
        add_row(11,      ROW_PREDICT);
        add_row(13,      ROW_PREDICT);
        add_row(29,      ROW_PREDICT);
        add_row(23,      ROW_PREDICT);
        add_row(59,      ROW_PREDICT);
        add_row(49,      ROW_PREDICT);
        add_row(121,     ROW_PREDICT);
        add_row(961,     ROW_PREDICT);
        add_row(77,      ROW_PREDICT);
        add_row(91,      ROW_PREDICT);
        add_row(CAND_MAX - 2, ROW_PREDICT);
        add_row(CAND_MAX - 4, ROW_PREDICT);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[j]) begin
            if (dir_rows[j].kind == ROW_PREDICT) begin
                want = classify(dir_rows[j].cand);
            end else begin
                want.is_prime = (dir_rows[j].kind == ROW_PRIME);
                want.form     = FORM_NONE;
                want.count    = '0;
            end
            offer_word(dir_rows[j].cand, want);
        end

        for (i = 0; i < RAND_ITEMS; i++) begin
            if (i >= RAND_ITEMS * 4 / 5) quiet_phase = 1'b1;
            begin
                logic [CAND_W-1:0] c;
                c = pick_candidate();
                offer_word(c, classify(c));
            end
        end
        i_in_valid <= 1'b0;

        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin : sink
        int       stall_left;
        int       seen;
        bit       held;
        t_verdict want;
        stall_left = 0;
        seen       = 0;
        held       = 1'b0;
        i_out_ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
                seen++;
                if (pending_verdicts.size() == 0) begin
                    $error("unexpected result word: is_prime %0d form_used %0d count %0d",
                           o_is_prime, o_form_used, o_solution_count);
                    err_count++;
                end else begin
                    want = pending_verdicts.pop_front();
                    if (o_is_prime !== want.is_prime) begin
                        $error("is_prime mismatch: expected %0d, actual %0d",
                               want.is_prime, o_is_prime);
                        err_count++;
                    end
                    if (o_form_used !== want.form) begin
                        $error("form_used mismatch: expected %0d, actual %0d",
                               want.form, o_form_used);
                        err_count++;
                    end
                    if (o_solution_count !== want.count) begin
                        $error("solution_count mismatch: expected %0d, actual %0d",
                               want.count, o_solution_count);
                        err_count++;
                    end
                end
            end
            // long hold-off once, otherwise short random stalls
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (!held && seen >= HOLD_AFTER) begin
                held        = 1'b1;
                stall_left  = HOLD_CYCLES - 1;
                i_out_ready <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
                stall_left  = $urandom_range(1, 8) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid === 1'b1 && o_in_ready === 1'b1) ||
                (o_out_valid === 1'b1 && i_out_ready === 1'b1))
                stuck = 0;
            else
                stuck++;
        end
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/apc_pkg.sv
rtl/apc_residue.sv
rtl/apc_form_count.sv
rtl/apc_sqfree.sv
rtl/atkin_prime_classifier.sv
sim/tb_top.sv
